// ===== rtl/jkl_pkg.sv =====
// Shared constants, request codes and controller/datapath bundles for the
// jackknife leave-one-out unit. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package jkl_pkg;

    localparam int MAX_POINTS  = 256;
    localparam int MAX_SAMPLES = 1024;
    localparam int MIN_SAMPLES = 3;
    localparam int VALUE_BITS  = 24;
    localparam int ERR_BITS    = VALUE_BITS - 1;
    localparam int IDX_BITS    = $clog2(MAX_POINTS);
    localparam int CFG_BITS    = 11;
    localparam int SUM_BITS    = 34;
    localparam int SQ_BITS     = 58;
    localparam int PROD_BITS   = 2 * VALUE_BITS;

    // divider: dividend magnitude and divisor (N-1 at most MAX_SAMPLES-1)
    localparam int DIV_W   = SQ_BITS;
    localparam int DVS_W   = $clog2(MAX_SAMPLES);
    localparam int DCNT_W  = $clog2(DIV_W + 1);

    // square root over a DIV_W radicand
    localparam int ROOT_W  = DIV_W / 2;
    localparam int SREM_W  = ROOT_W + 2;
    localparam int SCNT_W  = $clog2(ROOT_W + 1);

    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_ACC   = 2'd1;
    localparam logic [1:0] REQ_EMIT  = 2'd2;

    typedef enum logic [1:0] {
        DIV_MEAN,
        DIV_T,
        DIV_D
    } div_sel_t;

    typedef struct packed {
        logic     take;
        logic     mem_rd;
        logic     clr_wr;
        logic     acc_wr;
        logic     cap_diff;
        logic     div_start;
        div_sel_t div_sel;
        logic     cap_mean;
        logic     cap_t;
        logic     cap_d;
        logic     sqrt_start;
        logic     out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       div_busy;
        logic       sqrt_busy;
        logic       d_neg;
        logic       out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/jkl_if.sv =====
// Valid/ready channel interfaces for the input requests and the results.
// Depends on jkl_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface jkl_in_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        req_type;
    logic [jkl_pkg::IDX_BITS-1:0]      point_index;
    logic signed [jkl_pkg::VALUE_BITS-1:0] sample_value;

    modport source (output valid, req_type, point_index, sample_value, input ready);
    modport sink   (input valid, req_type, point_index, sample_value, output ready);
endinterface

interface jkl_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [jkl_pkg::IDX_BITS-1:0]          out_index;
    logic signed [jkl_pkg::VALUE_BITS-1:0] mean_value;
    logic [jkl_pkg::ERR_BITS-1:0]          error_value;

    modport source (output valid, out_index, mean_value, error_value, input ready);
    modport sink   (input valid, out_index, mean_value, error_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/jkl_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on jkl_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none
module jkl_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [jkl_pkg::DIV_W-1:0]  dividend,
    input  wire logic [jkl_pkg::DVS_W-1:0]  divisor,
    output logic                            busy,
    output logic [jkl_pkg::DIV_W-1:0]       quotient
);
    logic                          busy_reg;
    logic [jkl_pkg::DCNT_W-1:0]    cnt_reg;
    logic [jkl_pkg::DIV_W-1:0]     quo_reg;
    logic [jkl_pkg::DVS_W-1:0]     rem_reg;
    logic [jkl_pkg::DVS_W-1:0]     dvs_reg;
    logic [jkl_pkg::DVS_W:0]       rem_sh;
    logic [jkl_pkg::DVS_W:0]       rem_sub;
    logic                          ge;

    assign rem_sh  = {rem_reg, quo_reg[jkl_pkg::DIV_W-1]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};
    assign ge      = (rem_sh >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= jkl_pkg::DCNT_W'(jkl_pkg::DIV_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == jkl_pkg::DCNT_W'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[jkl_pkg::DIV_W-2:0], ge};
            rem_reg <= ge ? rem_sub[jkl_pkg::DVS_W-1:0] : rem_sh[jkl_pkg::DVS_W-1:0];
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

// ===== rtl/jkl_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on jkl_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none
module jkl_sqrt (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [jkl_pkg::DIV_W-1:0]  radicand,
    output logic                            busy,
    output logic [jkl_pkg::ROOT_W-1:0]      root
);
    logic                          busy_reg;
    logic [jkl_pkg::SCNT_W-1:0]    cnt_reg;
    logic [jkl_pkg::DIV_W-1:0]     rad_reg;
    logic [jkl_pkg::SREM_W-1:0]    rem_reg;
    logic [jkl_pkg::ROOT_W-1:0]    root_reg;
    logic [jkl_pkg::SREM_W+1:0]    rem_sh;
    logic [jkl_pkg::SREM_W+1:0]    trial;
    logic [jkl_pkg::SREM_W+1:0]    rem_sub;
    logic                          ge;

    assign rem_sh  = {rem_reg, rad_reg[jkl_pkg::DIV_W-1 -: 2]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign rem_sub = rem_sh - trial;
    assign ge      = (rem_sh >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= jkl_pkg::SCNT_W'(jkl_pkg::ROOT_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == jkl_pkg::SCNT_W'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[jkl_pkg::DIV_W-3:0], 2'b00};
            rem_reg  <= ge ? rem_sub[jkl_pkg::SREM_W-1:0] : rem_sh[jkl_pkg::SREM_W-1:0];
            root_reg <= {root_reg[jkl_pkg::ROOT_W-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;
endmodule
`default_nettype wire

// ===== rtl/jkl_datapath.sv =====
// Datapath: point sum memories, operand registers, shared divider, square
// root and the result register. Depends on jkl_pkg, jkl_div, jkl_sqrt.
`timescale 1ns / 1ps
`default_nettype none
module jkl_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [jkl_pkg::CFG_BITS-1:0]      cfg_wr_data,
    input  wire jkl_pkg::ctrl_cmd_t                cmd,
    output jkl_pkg::dp_stat_t                      stat,
    input  wire logic [1:0]                        in_req,
    input  wire logic [jkl_pkg::IDX_BITS-1:0]      in_idx,
    input  wire logic signed [jkl_pkg::VALUE_BITS-1:0] in_x,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [jkl_pkg::IDX_BITS-1:0]           out_idx,
    output logic signed [jkl_pkg::VALUE_BITS-1:0]  out_mean,
    output logic [jkl_pkg::ERR_BITS-1:0]           out_err
);
    localparam int MD_W = jkl_pkg::SUM_BITS + 1;
    localparam int TD_W = jkl_pkg::SQ_BITS + 1;
    localparam int D_W  = TD_W + 1;
    localparam logic [jkl_pkg::DIV_W-1:0] MEAN_POS_MAX =
        jkl_pkg::DIV_W'((1 << (jkl_pkg::VALUE_BITS - 1)) - 1);
    localparam logic [jkl_pkg::ROOT_W-1:0] ERR_MAX =
        jkl_pkg::ROOT_W'((1 << jkl_pkg::ERR_BITS) - 1);

    logic [jkl_pkg::SUM_BITS-1:0] sum_mem [jkl_pkg::MAX_POINTS];
    logic [jkl_pkg::SQ_BITS-1:0]  sq_mem  [jkl_pkg::MAX_POINTS];

    logic [jkl_pkg::CFG_BITS-1:0]          num_samples_reg;
    logic [1:0]                            req_reg;
    logic [jkl_pkg::IDX_BITS-1:0]          idx_reg;
    logic signed [jkl_pkg::VALUE_BITS-1:0] x_reg;
    logic [jkl_pkg::SUM_BITS-1:0]          sum_rd_reg;
    logic [jkl_pkg::SQ_BITS-1:0]           sq_rd_reg;
    logic [jkl_pkg::PROD_BITS-1:0]         xsq_reg;
    logic signed [MD_W-1:0]                mdiff_reg;
    logic signed [TD_W-1:0]                tdiff_reg;
    logic signed [jkl_pkg::VALUE_BITS-1:0] mean_reg;
    logic signed [TD_W-1:0]                t_reg;
    logic [jkl_pkg::PROD_BITS-1:0]         msq_reg;
    logic signed [D_W-1:0]                 d_reg;
    logic                                  out_valid_reg;
    logic [jkl_pkg::IDX_BITS-1:0]          out_idx_reg;
    logic signed [jkl_pkg::VALUE_BITS-1:0] out_mean_reg;
    logic [jkl_pkg::ERR_BITS-1:0]          out_err_reg;

    logic [jkl_pkg::CFG_BITS-1:0]          n_clamp;
    logic [jkl_pkg::CFG_BITS-1:0]          n_m1;
    logic [jkl_pkg::CFG_BITS-1:0]          n_m2;
    logic signed [jkl_pkg::PROD_BITS-1:0]  x_prod;
    logic signed [jkl_pkg::PROD_BITS-1:0]  m_prod;
    logic signed [MD_W-1:0]                mdiff_abs;
    logic signed [TD_W-1:0]                tdiff_abs;
    logic [jkl_pkg::DIV_W-1:0]             dividend;
    logic [jkl_pkg::DVS_W-1:0]             divisor;
    logic                                  div_busy;
    logic [jkl_pkg::DIV_W-1:0]             quo;
    logic                                  sqrt_busy;
    logic [jkl_pkg::ROOT_W-1:0]            root;
    logic signed [jkl_pkg::VALUE_BITS-1:0] mean_sat;
    logic signed [TD_W-1:0]                t_signed;

    // ensemble size clamped to the supported range
    always_comb
    begin
        priority if (num_samples_reg < jkl_pkg::CFG_BITS'(jkl_pkg::MIN_SAMPLES))
            n_clamp = jkl_pkg::CFG_BITS'(jkl_pkg::MIN_SAMPLES);
        else if (num_samples_reg > jkl_pkg::CFG_BITS'(jkl_pkg::MAX_SAMPLES))
            n_clamp = jkl_pkg::CFG_BITS'(jkl_pkg::MAX_SAMPLES);
        else
            n_clamp = num_samples_reg;
    end
    assign n_m1 = n_clamp - jkl_pkg::CFG_BITS'(1);
    assign n_m2 = n_clamp - jkl_pkg::CFG_BITS'(2);

    assign x_prod = x_reg * x_reg;
    assign m_prod = mean_reg * mean_reg;

    assign mdiff_abs = mdiff_reg[MD_W-1] ? -mdiff_reg : mdiff_reg;
    assign tdiff_abs = tdiff_reg[TD_W-1] ? -tdiff_reg : tdiff_reg;

    always_comb
    begin
        unique case (cmd.div_sel)
            jkl_pkg::DIV_MEAN:
                dividend = {{(jkl_pkg::DIV_W-MD_W){1'b0}}, mdiff_abs};
            jkl_pkg::DIV_T:
                dividend = tdiff_abs[jkl_pkg::DIV_W-1:0];
            jkl_pkg::DIV_D:
                dividend = d_reg[jkl_pkg::DIV_W-1:0];
            default:
                dividend = '0;
        endcase
    end
    assign divisor = (cmd.div_sel == jkl_pkg::DIV_D) ? n_m2[jkl_pkg::DVS_W-1:0]
                                                     : n_m1[jkl_pkg::DVS_W-1:0];

    // truncated quotient back to signed mean, saturated to the value range
    always_comb
    begin
        priority if (mdiff_reg[MD_W-1])
        begin
            if (quo > MEAN_POS_MAX + 1'b1)
                mean_sat = {1'b1, {(jkl_pkg::VALUE_BITS-1){1'b0}}};
            else
                mean_sat = -$signed(quo[jkl_pkg::VALUE_BITS-1:0]);
        end
        else if (quo > MEAN_POS_MAX)
            mean_sat = {1'b0, {(jkl_pkg::VALUE_BITS-1){1'b1}}};
        else
            mean_sat = $signed(quo[jkl_pkg::VALUE_BITS-1:0]);
    end
    assign t_signed = tdiff_reg[TD_W-1] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

    jkl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .busy     (div_busy),
        .quotient (quo)
    );

    jkl_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (quo),
        .busy     (sqrt_busy),
        .root     (root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_samples_reg <= jkl_pkg::CFG_BITS'(jkl_pkg::MIN_SAMPLES);
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                num_samples_reg <= cfg_wr_data;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_wr)
        begin
            sum_mem[idx_reg] <= '0;
            sq_mem[idx_reg]  <= '0;
        end
        else if (cmd.acc_wr)
        begin
            sum_mem[idx_reg] <= sum_rd_reg + jkl_pkg::SUM_BITS'(x_reg);
            sq_mem[idx_reg]  <= sq_rd_reg + jkl_pkg::SQ_BITS'(xsq_reg);
        end
        if (cmd.mem_rd)
        begin
            sum_rd_reg <= sum_mem[idx_reg];
            sq_rd_reg  <= sq_mem[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            req_reg <= in_req;
            idx_reg <= in_idx;
            x_reg   <= in_x;
        end
        if (cmd.mem_rd)
            xsq_reg <= x_prod;
        if (cmd.cap_diff)
        begin
            mdiff_reg <= MD_W'($signed(sum_rd_reg)) - MD_W'(x_reg);
            tdiff_reg <= $signed({1'b0, sq_rd_reg}) - $signed(TD_W'(xsq_reg));
        end
        if (cmd.cap_mean)
            mean_reg <= mean_sat;
        if (cmd.cap_t)
        begin
            t_reg   <= t_signed;
            msq_reg <= m_prod;
        end
        if (cmd.cap_d)
            d_reg <= D_W'(t_reg) - $signed(D_W'(msq_reg));
        if (cmd.out_load)
        begin
            out_idx_reg  <= idx_reg;
            out_mean_reg <= mean_reg;
            priority if (d_reg[D_W-1])
                out_err_reg <= '0;
            else if (root > ERR_MAX)
                out_err_reg <= ERR_MAX[jkl_pkg::ERR_BITS-1:0];
            else
                out_err_reg <= root[jkl_pkg::ERR_BITS-1:0];
        end
    end

    assign stat.req       = req_reg;
    assign stat.div_busy  = div_busy;
    assign stat.sqrt_busy = sqrt_busy;
    assign stat.d_neg     = d_reg[D_W-1];
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_idx   = out_idx_reg;
    assign out_mean  = out_mean_reg;
    assign out_err   = out_err_reg;
endmodule
`default_nettype wire

// ===== rtl/jkl_ctrl.sv =====
// Controller state machine sequencing memory access for each request and the
// divisions and square root for emit requests. Depends on jkl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module jkl_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire jkl_pkg::dp_stat_t  stat,
    output jkl_pkg::ctrl_cmd_t      cmd
);
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ACC_WR,
        S_DIFF,
        S_DIV1_GO,
        S_DIV1,
        S_DIV2_GO,
        S_DIV2,
        S_DSUB,
        S_DIV3_GO,
        S_DIV3,
        S_SQ_GO,
        S_SQ,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        cmd.div_sel = jkl_pkg::DIV_MEAN;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.mem_rd = 1'b1;
                unique case (stat.req)
                    jkl_pkg::REQ_CLEAR:
                    begin
                        cmd.clr_wr = 1'b1;
                        state_next = S_IDLE;
                    end
                    jkl_pkg::REQ_ACC:  state_next = S_ACC_WR;
                    jkl_pkg::REQ_EMIT: state_next = S_DIFF;
                    default:           state_next = S_IDLE;
                endcase
            end
            S_ACC_WR:
            begin
                cmd.acc_wr = 1'b1;
                state_next = S_IDLE;
            end
            S_DIFF:
            begin
                cmd.cap_diff = 1'b1;
                state_next   = S_DIV1_GO;
            end
            S_DIV1_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV1;
            end
            S_DIV1:
            begin
                if (!stat.div_busy)
                begin
                    cmd.cap_mean = 1'b1;
                    state_next   = S_DIV2_GO;
                end
            end
            S_DIV2_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = jkl_pkg::DIV_T;
                state_next    = S_DIV2;
            end
            S_DIV2:
            begin
                cmd.div_sel = jkl_pkg::DIV_T;
                if (!stat.div_busy)
                begin
                    cmd.cap_t  = 1'b1;
                    state_next = S_DSUB;
                end
            end
            S_DSUB:
            begin
                cmd.cap_d  = 1'b1;
                state_next = S_DIV3_GO;
            end
            S_DIV3_GO:
            begin
                cmd.div_sel = jkl_pkg::DIV_D;
                // negative radicand: skip straight to a zero error
                if (stat.d_neg)
                    state_next = S_OUT;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV3;
                end
            end
            S_DIV3:
            begin
                cmd.div_sel = jkl_pkg::DIV_D;
                if (!stat.div_busy)
                    state_next = S_SQ_GO;
            end
            S_SQ_GO:
            begin
                cmd.sqrt_start = 1'b1;
                state_next     = S_SQ;
            end
            S_SQ:
            begin
                if (!stat.sqrt_busy)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                // hold until the result register is free
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == S_IDLE);
endmodule
`default_nettype wire

// ===== rtl/jackknife_leave_one_out_unit.sv =====
// Top level of the jackknife leave-one-out unit.
// Depends on jkl_pkg, jkl_if, jkl_ctrl and jkl_datapath.
//
// Usage:
//   in_ch carries one request per beat: clear a point, accumulate a sample
//   into a point, or emit the leave-one-out mean and error for a sample.
//   out_ch carries one result beat per emit request; clear and accumulate
//   requests and the unused request code give no result.
//   cfg_wr_en/cfg_wr_data write the ensemble size N (reset value 3);
//   write it only while no request is in flight.
// Sequencing:
//   One request at a time. Emit makes three passes of the shared
//   bit-serial divider (by N-1 twice, by N-2 once) and then the square
//   root; with a negative radicand the last divide and the root are
//   skipped.
// Reset: control state and the result valid are cleared; the point
//   memories are not, so each point must be cleared before use.
// Stall: a finished result waits in the output register; the unit keeps
//   taking clear and accumulate requests, and a later emit holds at its
//   end until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none
module jackknife_leave_one_out_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [jkl_pkg::CFG_BITS-1:0]  cfg_wr_data,
    jkl_in_if.sink                             in_ch,
    jkl_out_if.source                          out_ch
);
    jkl_pkg::ctrl_cmd_t cmd;
    jkl_pkg::dp_stat_t  stat;

    jkl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    jkl_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .stat        (stat),
        .in_req      (in_ch.req_type),
        .in_idx      (in_ch.point_index),
        .in_x        (in_ch.sample_value),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .out_idx     (out_ch.out_index),
        .out_mean    (out_ch.mean_value),
        .out_err     (out_ch.error_value)
    );
endmodule
`default_nettype wire

// ===== rtl/jkl_checker.sv =====
// Port-level checker for the jackknife leave-one-out unit, bound to the top.
// Depends on jkl_pkg and jackknife_leave_one_out_unit.
`timescale 1ns / 1ps
`default_nettype none
module jkl_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [jkl_pkg::IDX_BITS-1:0]  out_index,
    input wire logic [jkl_pkg::VALUE_BITS-1:0] mean_value,
    input wire logic [jkl_pkg::ERR_BITS-1:0]  error_value
);
    // a result beat holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable(out_index) && $stable(mean_value) && $stable(error_value))
        else $error("result payload changed while stalled");

    // one request at a time: no accept in the cycle after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request accepted back to back");

    // a result never appears the cycle after a request beat
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result raised too early after a request");
endmodule

bind jackknife_leave_one_out_unit jkl_checker u_jkl_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_index   (out_ch.out_index),
    .mean_value  (out_ch.mean_value),
    .error_value (out_ch.error_value)
);
`default_nettype wire

// ===== bench/jackknife_leave_one_out_unit_tb.sv =====
// Testbench for the jackknife leave-one-out unit: drives clear, accumulate and emit
// beats, predicts each result in fixed point and compares it field by field.
// Depends on jkl_pkg, jkl_if and the unit's RTL.
`timescale 1ns / 1ps
module jackknife_leave_one_out_unit_tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 300;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [jkl_pkg::IDX_BITS-1:0]          idx;
        logic signed [jkl_pkg::VALUE_BITS-1:0] mean;
        logic [jkl_pkg::ERR_BITS-1:0]          err;
    } loo_result_t;

    typedef struct {
        logic [1:0]                            req;
        logic [jkl_pkg::IDX_BITS-1:0]          idx;
        logic signed [jkl_pkg::VALUE_BITS-1:0] x;
        bit                                    fixed;
        loo_result_t                           want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [jkl_pkg::CFG_BITS-1:0] cfg_wr_data = '0;

    jkl_in_if  in_ch();
    jkl_out_if out_ch();

    jackknife_leave_one_out_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic signed [jkl_pkg::SUM_BITS-1:0] point_sum [jkl_pkg::MAX_POINTS];
    logic [jkl_pkg::SQ_BITS-1:0]         point_sqsum [jkl_pkg::MAX_POINTS];
    bit                                  point_cleared [jkl_pkg::MAX_POINTS];
    int                                  ensemble_n = 3;
    loo_result_t                         pending_results[$];
    int                                  fail_count = 0;
    int                                  idle_cycles = 0;
    bit                                  rx_stall_on = 1'b1;
    bit                                  tx_gap_on = 1'b1;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic longint int_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= root + b)
            begin
                v -= root + b;
                root = (root >> 1) + b;
            end
            else
                root >>= 1;
            b >>= 2;
        end
        return root;
    endfunction

    function automatic loo_result_t loo_estimate(
        input logic [jkl_pkg::IDX_BITS-1:0] idx,
        input logic signed [jkl_pkg::VALUE_BITS-1:0] x);
        loo_result_t r;
        longint n, s, m, t, d, xv, mmax;
        longint unsigned e;
        n = ensemble_n < jkl_pkg::MIN_SAMPLES ? jkl_pkg::MIN_SAMPLES :
            (ensemble_n > jkl_pkg::MAX_SAMPLES ? jkl_pkg::MAX_SAMPLES : ensemble_n);
        xv = x;
        s = point_sum[idx];
        m = (s - xv) / (n - 1);
        mmax = (64'sd1 <<< (jkl_pkg::VALUE_BITS - 1)) - 1;
        if (m > mmax) m = mmax;
        if (m < -mmax - 1) m = -mmax - 1;
        t = (longint'({6'd0, point_sqsum[idx]}) - xv * xv) / (n - 1);
        d = t - m * m;
        if (d < 0)
            e = 0;
        else
        begin
            e = int_sqrt(d / (n - 2));
            if (e > (64'd1 << jkl_pkg::ERR_BITS) - 1) e = (64'd1 << jkl_pkg::ERR_BITS) - 1;
        end
        r.idx = idx;
        r.mean = m[jkl_pkg::VALUE_BITS-1:0];
        r.err = e[jkl_pkg::ERR_BITS-1:0];
        return r;
    endfunction

    // update the model with one accepted beat
    task automatic apply_beat(input logic [1:0] req, input logic [jkl_pkg::IDX_BITS-1:0] idx,
                              input logic signed [jkl_pkg::VALUE_BITS-1:0] x);
        longint xv;
        xv = x;
        if (req == jkl_pkg::REQ_CLEAR)
        begin
            point_sum[idx] = '0;
            point_sqsum[idx] = '0;
            point_cleared[idx] = 1'b1;
        end
        else if (req == jkl_pkg::REQ_ACC)
        begin
            point_sum[idx] = point_sum[idx] + jkl_pkg::SUM_BITS'(xv);
            point_sqsum[idx] = point_sqsum[idx] + jkl_pkg::SQ_BITS'(xv * xv);
        end
        else if (req == jkl_pkg::REQ_EMIT)
            pending_results.push_back(loo_estimate(idx, x));
    endtask

    task automatic send_beat(input logic [1:0] req, input logic [jkl_pkg::IDX_BITS-1:0] idx,
                             input logic signed [jkl_pkg::VALUE_BITS-1:0] x);
        while (tx_gap_on && $urandom_range(99) < 35)
            @(posedge clk);
        in_ch.valid <= 1'b1;
        in_ch.req_type <= req;
        in_ch.point_index <= idx;
        in_ch.sample_value <= x;
        do @(posedge clk); while (!in_ch.ready);
        apply_beat(req, idx, x);
        // drop valid for the cycle after the beat, while the unit is busy
        in_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_ensemble(input int n);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= jkl_pkg::CFG_BITS'(n);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        ensemble_n = n;
    endtask

    // one ensemble of a point: clear, n samples, emit some of them back
    task automatic run_ensemble(input int n, input logic [jkl_pkg::IDX_BITS-1:0] idx,
                                input int emits);
        logic signed [jkl_pkg::VALUE_BITS-1:0] samples[$];
        logic signed [jkl_pkg::VALUE_BITS-1:0] v;
        int span;
        span = $urandom_range(3);
        send_beat(jkl_pkg::REQ_CLEAR, idx, jkl_pkg::VALUE_BITS'($urandom));
        for (int i = 0; i < n; i++)
        begin
            case (span)
                0: v = jkl_pkg::VALUE_BITS'($urandom);
                1: v = jkl_pkg::VALUE_BITS'($signed($urandom_range(2000)) - 1000);
                default: v = jkl_pkg::VALUE_BITS'(32'sd65536 * 3 +
                                                  $signed($urandom_range(65535)));
            endcase
            samples.push_back(v);
            send_beat(jkl_pkg::REQ_ACC, idx, v);
        end
        for (int i = 0; i < emits; i++)
            send_beat(jkl_pkg::REQ_EMIT, idx, samples[$urandom_range(samples.size() - 1)]);
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result beat with none pending", 1, 0);
            else
            begin
                loo_result_t want;
                want = pending_results.pop_front();
                if (out_ch.out_index !== want.idx)
                    report_mismatch("out_index", out_ch.out_index, want.idx);
                if (out_ch.mean_value !== want.mean)
                    report_mismatch("mean_value", out_ch.mean_value, want.mean);
                if (out_ch.error_value !== want.err)
                    report_mismatch("error_value", out_ch.error_value, want.err);
            end
        end
    end

    always @(posedge clk)
        out_ch.ready <= !rx_stall_on || $urandom_range(99) >= 35;

    // watchdog: no beat moving on either side for too long
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("[jackknife_leave_one_out_unit] ERROR");
            $finish;
        end
    end

    stim_row_t directed[$];

    task automatic add_row(input logic [1:0] req, input logic [jkl_pkg::IDX_BITS-1:0] idx,
                           input logic signed [jkl_pkg::VALUE_BITS-1:0] x, input bit fixed,
                           input loo_result_t want);
        stim_row_t r;
        r.req = req; r.idx = idx; r.x = x; r.fixed = fixed; r.want = want;
        directed.push_back(r);
    endtask

    initial
    begin
        int n_cfg;
        in_ch.valid = 1'b0;
        in_ch.req_type = jkl_pkg::REQ_CLEAR;
        in_ch.point_index = '0;
        in_ch.sample_value = '0;
        out_ch.ready = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset N is 3: three equal samples give mean x, error 0
        add_row(jkl_pkg::REQ_CLEAR, 8'd0, 24'sd0, 0, '0);
        add_row(jkl_pkg::REQ_ACC, 8'd0, 24'sd65536, 0, '0);
        add_row(jkl_pkg::REQ_ACC, 8'd0, 24'sd65536, 0, '0);
        add_row(jkl_pkg::REQ_ACC, 8'd0, 24'sd65536, 0, '0);
        add_row(jkl_pkg::REQ_EMIT, 8'd0, 24'sd65536, 1, '{8'd0, 24'sd65536, 23'd0});
        // extremes of the sample range on the top point
        add_row(jkl_pkg::REQ_CLEAR, 8'd255, 24'sd0, 0, '0);
        add_row(jkl_pkg::REQ_ACC, 8'd255, 24'h7fffff, 0, '0);
        add_row(jkl_pkg::REQ_ACC, 8'd255, 24'h800000, 0, '0);
        add_row(jkl_pkg::REQ_ACC, 8'd255, 24'h7fffff, 0, '0);
        add_row(jkl_pkg::REQ_EMIT, 8'd255, 24'h800000, 0, '0);
        add_row(jkl_pkg::REQ_EMIT, 8'd255, 24'h7fffff, 0, '0);
        // unknown request code: no result
        add_row(REQ_UNKNOWN, 8'd0, 24'h5a5a5a, 0, '0);
        // more samples than N: saturation, negative radicand
        add_row(jkl_pkg::REQ_ACC, 8'd0, 24'h800000, 0, '0);
        add_row(jkl_pkg::REQ_ACC, 8'd0, 24'h800000, 0, '0);
        add_row(jkl_pkg::REQ_EMIT, 8'd0, 24'h7fffff, 0, '0);
        add_row(jkl_pkg::REQ_CLEAR, 8'd170, 24'sd0, 0, '0);
        add_row(jkl_pkg::REQ_EMIT, 8'd170, 24'h7fffff, 0, '0);
        add_row(jkl_pkg::REQ_EMIT, 8'd170, 24'sd0, 1, '{8'd170, 24'sd0, 23'd0});
        foreach (directed[i])
        begin
            send_beat(directed[i].req, directed[i].idx, directed[i].x);
            if (directed[i].fixed && pending_results.size() != 0)
                pending_results[$] = directed[i].want;
        end

        // hold the sender until every result has come
        wait_drained();
        rx_stall_on = 1'b0;
        tx_gap_on = 1'b0;
        run_ensemble(3, 8'd85, 3);
        rx_stall_on = 1'b1;
        tx_gap_on = 1'b1;

        write_ensemble(1024);
        run_ensemble(20, 8'd7, 2);
        write_ensemble(2);
        run_ensemble(3, 8'd9, 2);
        write_ensemble(2047);
        run_ensemble(3, 8'd9, 1);
        for (int phase = 0; phase < 4; phase++)
        begin
            n_cfg = (phase == 0) ? 3 : $urandom_range(3, 12);
            write_ensemble(n_cfg);
            for (int k = 0; k < 10; k++)
                run_ensemble(n_cfg, jkl_pkg::IDX_BITS'($urandom), $urandom_range(1, 3));
            // noise: stray beats, unknown codes, emits on cleared points
            for (int k = 0; k < 10; k++)
            begin
                logic [jkl_pkg::IDX_BITS-1:0] pi;
                logic [1:0] rq;
                pi = jkl_pkg::IDX_BITS'($urandom);
                rq = 2'($urandom_range(3));
                if (rq != jkl_pkg::REQ_CLEAR && !point_cleared[pi])
                    rq = REQ_UNKNOWN;
                send_beat(rq, pi, jkl_pkg::VALUE_BITS'($urandom));
            end
        end

        wait_drained();
        if (fail_count == 0)
            $display("[jackknife_leave_one_out_unit] OK");
        else
            $display("[jackknife_leave_one_out_unit] ERROR");
        $finish;
    end
endmodule
